FILE: rtl/core/lfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED flash sequencer package
// Shared widths, action, mode and pending-command codes, count saturation.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int CNT_BITS = 8;
  localparam int FIELD_BITS = 8;
  localparam int SAT_BITS = (CNT_BITS > FIELD_BITS) ? CNT_BITS : FIELD_BITS;

  typedef logic [CNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX = {CNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_ON    = 3'd1,
    ACT_OFF   = 3'd2,
    ACT_FLASH = 3'd3,
    ACT_POLL  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_FON  = 2'd2,
    MODE_FOFF = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_ON    = 2'd1,
    PEND_OFF   = 2'd2,
    PEND_FLASH = 2'd3
  } pend_t;

  // Clamp an 8-bit field to the largest count value.
  function automatic cnt_t sat_count(input logic [FIELD_BITS-1:0] v);
    logic [SAT_BITS-1:0] wide;
    wide = SAT_BITS'(v);
    if (wide > SAT_BITS'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return cnt_t'(wide);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/led_flash_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED flash sequencer top level
// Registered command/tick processor driving one LED level.
// ----------------------------------------------------------------------------
// One result transaction comes out for every input transaction, in order.
// An item is captured in an input register, processed against the sequencer
// state by combinational compare-and-count logic, and lands in a result
// register; one item is taken every cycle while the result side does not
// stall. On, off and flash commands are held as pending and take effect on
// the next tick; a poll returns and clears the sticky end flag. The
// end-event enable is written through the cfg port, which is always ready,
// and should only be changed while no transaction is in flight.
module led_flash_sequencer_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_action,
  input  wire logic [7:0]         in_flash_count,
  input  wire logic [7:0]         in_on_ticks,
  input  wire logic [7:0]         in_off_ticks,
  input  wire logic               in_final_off,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_led_level,
  output logic                    out_end_event,
  output logic [1:0]              out_mode,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_end_event_enable
);
  import lfs_pkg::*;

  // input stage
  logic       s1_valid_r;
  action_t    s1_action_r;
  logic [7:0] s1_count_r;
  logic [7:0] s1_on_r;
  logic [7:0] s1_off_r;
  logic       s1_final_r;

  // sequencer state
  logic  ev_en_r;
  mode_t mode_r, mode_nxt;
  pend_t pend_r, pend_nxt;
  cnt_t  total_r, total_nxt;
  cnt_t  on_len_r, on_len_nxt;
  cnt_t  off_len_r, off_len_nxt;
  logic  end_after_on_r, end_after_on_nxt;
  cnt_t  period_r, period_nxt;
  cnt_t  done_r, done_nxt;
  logic  end_flag_r, end_flag_nxt;
  logic  led_r, led_nxt;
  logic  ev_nxt;

  // result stage
  logic       out_valid_r;
  logic       out_led_r;
  logic       out_ev_r;
  mode_t      out_mode_r;

  logic out_take;
  logic s1_adv;
  logic s1_take;

  // working values after applying the pending command
  mode_t    mode_a;
  logic     led_a;
  cnt_t     period_a;
  cnt_t     done_a;
  cnt_t     done_inc;
  logic [CNT_BITS:0] done_p1;

  assign out_take  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_take;
  assign s1_take   = !s1_valid_r || out_take;
  assign in_stall  = !s1_take;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_led_level = out_led_r;
  assign out_end_event = out_ev_r;
  assign out_mode      = out_mode_r;

  always_comb begin
    mode_nxt         = mode_r;
    pend_nxt         = pend_r;
    total_nxt        = total_r;
    on_len_nxt       = on_len_r;
    off_len_nxt      = off_len_r;
    end_after_on_nxt = end_after_on_r;
    period_nxt       = period_r;
    done_nxt         = done_r;
    end_flag_nxt     = end_flag_r;
    led_nxt          = led_r;
    ev_nxt           = 1'b0;

    mode_a   = mode_r;
    led_a    = led_r;
    period_a = period_r;
    done_a   = done_r;
    unique case (pend_r)
      PEND_ON: begin
        mode_a = MODE_ON;
        led_a  = 1'b1;
      end
      PEND_OFF: begin
        mode_a = MODE_OFF;
        led_a  = 1'b0;
      end
      PEND_FLASH: begin
        mode_a   = MODE_FON;
        led_a    = 1'b1;
        period_a = '0;
        done_a   = '0;
      end
      default: begin
      end
    endcase
    done_p1  = {1'b0, done_a} + (CNT_BITS+1)'(1);
    done_inc = done_p1[CNT_BITS-1:0];

    if (s1_valid_r) begin
      unique case (s1_action_r)
        ACT_TICK: begin
          pend_nxt   = PEND_NONE;
          mode_nxt   = mode_a;
          led_nxt    = led_a;
          period_nxt = period_a;
          done_nxt   = done_a;
          if (mode_a == MODE_FON) begin
            if (period_a >= on_len_r) begin
              period_nxt = '0;
              if (end_after_on_r && total_r != '0 && done_p1 >= {1'b0, total_r}) begin
                mode_nxt = MODE_OFF;
                led_nxt  = 1'b0;
                if (ev_en_r) begin
                  end_flag_nxt = 1'b1;
                end
              end else begin
                mode_nxt = MODE_FOFF;
                led_nxt  = 1'b0;
              end
            end else begin
              period_nxt = period_a + cnt_t'(1);
            end
          end else if (mode_a == MODE_FOFF) begin
            if (period_a >= off_len_r) begin
              period_nxt = '0;
              done_nxt   = done_inc;
              if (total_r != '0 && done_inc >= total_r) begin
                mode_nxt = MODE_OFF;
                led_nxt  = 1'b0;
                if (ev_en_r) begin
                  end_flag_nxt = 1'b1;
                end
              end else begin
                mode_nxt = MODE_FON;
                led_nxt  = 1'b1;
              end
            end else begin
              period_nxt = period_a + cnt_t'(1);
            end
          end
        end
        ACT_ON: begin
          pend_nxt = PEND_ON;
        end
        ACT_OFF: begin
          pend_nxt = PEND_OFF;
        end
        ACT_FLASH: begin
          pend_nxt         = PEND_FLASH;
          total_nxt        = sat_count(s1_count_r);
          on_len_nxt       = sat_count(s1_on_r);
          off_len_nxt      = sat_count(s1_off_r);
          end_after_on_nxt = s1_final_r;
        end
        ACT_POLL: begin
          ev_nxt       = end_flag_r;
          end_flag_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      ev_en_r        <= 1'b0;
      mode_r         <= MODE_OFF;
      pend_r         <= PEND_NONE;
      total_r        <= '0;
      on_len_r       <= '0;
      off_len_r      <= '0;
      end_after_on_r <= 1'b0;
      period_r       <= '0;
      done_r         <= '0;
      end_flag_r     <= 1'b0;
      led_r          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ev_en_r <= cfg_end_event_enable;
      end
      if (s1_take) begin
        s1_valid_r <= in_valid;
      end
      if (out_take) begin
        out_valid_r <= s1_valid_r;
      end
      // commit state only when the transaction moves to the result register
      if (s1_adv) begin
        mode_r         <= mode_nxt;
        pend_r         <= pend_nxt;
        total_r        <= total_nxt;
        on_len_r       <= on_len_nxt;
        off_len_r      <= off_len_nxt;
        end_after_on_r <= end_after_on_nxt;
        period_r       <= period_nxt;
        done_r         <= done_nxt;
        end_flag_r     <= end_flag_nxt;
        led_r          <= led_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_action_r <= action_t'(in_action);
      s1_count_r  <= in_flash_count;
      s1_on_r     <= in_on_ticks;
      s1_off_r    <= in_off_ticks;
      s1_final_r  <= in_final_off;
    end
    if (s1_adv) begin
      out_led_r  <= led_nxt;
      out_ev_r   <= ev_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  // LED level follows the mode
  a_led_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ON || mode_r == MODE_FON) |-> led_r)
    else $error("LED dark in a lit mode");

  a_led_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_OFF || mode_r == MODE_FOFF) |-> !led_r)
    else $error("LED lit in a dark mode");

  a_tick_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == ACT_TICK) |=> (pend_r == PEND_NONE))
    else $error("pending command survived a tick");

  a_poll_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == ACT_POLL) |=> !end_flag_r)
    else $error("end flag not cleared by poll");

  a_no_flag_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (!ev_en_r && !end_flag_r && !(cfg_valid && cfg_ready)) |=> !end_flag_r)
    else $error("end flag set while end event disabled");

endmodule
`default_nettype wire

FILE: bench/led_flash_sequencer_checker.sv
// ----------------------------------------------------------------------------
// LED flash sequencer checker
// Watches the command, result and configuration channels, keeps its own copy
// of the sequencer state, predicts one report per accepted command and
// compares the reports that come out, in order, field by field.
// ----------------------------------------------------------------------------
module led_flash_sequencer_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [2:0] in_action,
  input  wire logic [7:0] in_flash_count,
  input  wire logic [7:0] in_on_ticks,
  input  wire logic [7:0] in_off_ticks,
  input  wire logic       in_final_off,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic       out_led_level,
  input  wire logic       out_end_event,
  input  wire logic [1:0] out_mode,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic       cfg_end_event_enable,
  output int              error_count,
  output int              reports_owed
);
  import lfs_pkg::*;

  typedef struct packed {
    logic  led_level;
    logic  end_event;
    mode_t mode;
  } led_report_t;

  led_report_t led_reports_due[$];

  // Shadow of the sequencer
  logic  end_evt_en;
  mode_t seq_mode;
  pend_t pend_cmd;
  cnt_t  flash_total;
  cnt_t  on_len;
  cnt_t  off_len;
  logic  stop_after_on;
  cnt_t  phase_cnt;
  cnt_t  flash_done;
  logic  end_seen;
  logic  led_lit;

  initial begin
    error_count  = 0;
    reports_owed = 0;
  end

  function automatic cnt_t clamp_count(input logic [7:0] v);
    if (32'(v) > 32'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return cnt_t'(v);
  endfunction

  function automatic void close_sequence();
    led_lit  = 1'b0;
    seq_mode = MODE_OFF;
    if (end_evt_en) begin
      end_seen = 1'b1;
    end
  endfunction

  function automatic led_report_t next_led_report(input logic [2:0] act,
                                                   input logic [7:0] count_f,
                                                   input logic [7:0] on_f,
                                                   input logic [7:0] off_f,
                                                   input logic       final_f);
    led_report_t rep;
    logic        polled;
    polled = 1'b0;
    case (act)
      ACT_TICK: begin
        // pending command lands first, then the running mode moves one tick
        case (pend_cmd)
          PEND_ON: begin
            seq_mode = MODE_ON;
            led_lit  = 1'b1;
          end
          PEND_OFF: begin
            seq_mode = MODE_OFF;
            led_lit  = 1'b0;
          end
          PEND_FLASH: begin
            seq_mode   = MODE_FON;
            flash_done = '0;
            phase_cnt  = '0;
            led_lit    = 1'b1;
          end
          default: ;
        endcase
        pend_cmd = PEND_NONE;
        case (seq_mode)
          MODE_FON: begin
            if (phase_cnt >= on_len) begin
              phase_cnt = '0;
              if (stop_after_on && flash_total != '0 &&
                  int'(flash_done) + 1 >= int'(flash_total)) begin
                close_sequence();
              end else begin
                led_lit  = 1'b0;
                seq_mode = MODE_FOFF;
              end
            end else begin
              phase_cnt = phase_cnt + cnt_t'(1);
            end
          end
          MODE_FOFF: begin
            if (phase_cnt >= off_len) begin
              phase_cnt  = '0;
              flash_done = flash_done + cnt_t'(1);
              if (flash_total != '0 && flash_done >= flash_total) begin
                close_sequence();
              end else begin
                led_lit  = 1'b1;
                seq_mode = MODE_FON;
              end
            end else begin
              phase_cnt = phase_cnt + cnt_t'(1);
            end
          end
          default: ;
        endcase
      end
      ACT_ON: pend_cmd = PEND_ON;
      ACT_OFF: pend_cmd = PEND_OFF;
      ACT_FLASH: begin
        // parameters take hold at once, the restart waits for a tick
        pend_cmd      = PEND_FLASH;
        flash_total   = clamp_count(count_f);
        on_len        = clamp_count(on_f);
        off_len       = clamp_count(off_f);
        stop_after_on = final_f;
      end
      ACT_POLL: begin
        polled   = end_seen;
        end_seen = 1'b0;
      end
      default: ;
    endcase
    rep.led_level = led_lit;
    rep.end_event = polled;
    rep.mode      = seq_mode;
    return rep;
  endfunction

  always @(posedge clk) begin
    led_report_t due;
    if (!rst_n) begin
      end_evt_en    = 1'b0;
      seq_mode      = MODE_OFF;
      pend_cmd      = PEND_NONE;
      flash_total   = '0;
      on_len        = '0;
      off_len       = '0;
      stop_after_on = 1'b0;
      phase_cnt     = '0;
      flash_done    = '0;
      end_seen      = 1'b0;
      led_lit       = 1'b0;
      led_reports_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        end_evt_en = cfg_end_event_enable;
      end
      // retire the oldest report before queuing the one for this edge
      if (out_valid && !out_stall) begin
        if (led_reports_due.size() == 0) begin
          $error("report with none due: led_level %0d end_event %0d mode %0d",
                 out_led_level, out_end_event, out_mode);
          error_count++;
        end else begin
          due = led_reports_due.pop_front();
          if (out_led_level !== due.led_level) begin
            $error("led_level expected %0d actual %0d", due.led_level, out_led_level);
            error_count++;
          end
          if (out_end_event !== due.end_event) begin
            $error("end_event expected %0d actual %0d", due.end_event, out_end_event);
            error_count++;
          end
          if (out_mode !== due.mode) begin
            $error("mode expected %0d actual %0d", due.mode, out_mode);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        led_reports_due.push_back(next_led_report(in_action, in_flash_count,
                                                  in_on_ticks, in_off_ticks,
                                                  in_final_off));
      end
    end
    reports_owed = led_reports_due.size();
  end

endmodule

FILE: bench/tb_led_flash_sequencer_top.sv
// ----------------------------------------------------------------------------
// LED flash sequencer testbench
// Drives tick, command and poll transactions with random gaps and result
// back-pressure, switches the end-event enable between phases and reports
// the verdict from the checker's error count and its count of owed reports.
// ----------------------------------------------------------------------------
module tb_led_flash_sequencer_top;
  import lfs_pkg::*;

  localparam logic [2:0] ACT_SPARE_FIRST  = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST   = 3'd7;
  localparam int         ITEM_TARGET      = 1250;
  localparam int         CFG_PHASE_ITEMS  = 250;
  localparam int         CALM_TAIL_ITEMS  = 200;
  localparam int         LONG_HOLD_CYCLES = 60;

  logic       clk;
  logic       rst_n                = 1'b0;
  logic       in_valid             = 1'b0;
  logic       in_stall;
  logic [2:0] in_action            = ACT_TICK;
  logic [7:0] in_flash_count       = '0;
  logic [7:0] in_on_ticks          = '0;
  logic [7:0] in_off_ticks         = '0;
  logic       in_final_off         = 1'b0;
  logic       out_valid;
  logic       out_stall            = 1'b0;
  logic       out_led_level;
  logic       out_end_event;
  logic [1:0] out_mode;
  logic       cfg_valid            = 1'b0;
  logic       cfg_ready;
  logic       cfg_end_event_enable = 1'b0;

  int error_count;
  int reports_owed;
  int items_sent     = 0;
  bit tx_gaps        = 1'b1;
  bit rx_gaps        = 1'b1;
  bit long_hold_req  = 1'b0;

  led_flash_sequencer_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_flash_count       (in_flash_count),
    .in_on_ticks          (in_on_ticks),
    .in_off_ticks         (in_off_ticks),
    .in_final_off         (in_final_off),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_led_level        (out_led_level),
    .out_end_event        (out_end_event),
    .out_mode             (out_mode),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_end_event_enable (cfg_end_event_enable)
  );

  led_flash_sequencer_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_flash_count       (in_flash_count),
    .in_on_ticks          (in_on_ticks),
    .in_off_ticks         (in_off_ticks),
    .in_final_off         (in_final_off),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_led_level        (out_led_level),
    .out_end_event        (out_end_event),
    .out_mode             (out_mode),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_end_event_enable (cfg_end_event_enable),
    .error_count          (error_count),
    .reports_owed         (reports_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_led_flash_sequencer_top: errors");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [2:0] act, input logic [7:0] count_f,
                           input logic [7:0] on_f, input logic [7:0] off_f,
                           input logic final_f);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_flash_count <= count_f;
    in_on_ticks    <= on_f;
    in_off_ticks   <= off_f;
    in_final_off   <= final_f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Flash fields ride along with random content; only a flash command uses them.
  task automatic send_simple(input logic [2:0] act);
    send_item(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    @(negedge clk);
    while (reports_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_end_enable(input logic en);
    cfg_valid            <= 1'b1;
    cfg_end_event_enable <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_length();
    if ($urandom_range(0, 29) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(0, 3));
  endfunction

  task automatic run_scenario();
    int         kind;
    int         n_ticks;
    bit         noisy;
    logic [7:0] count_f;
    logic [7:0] on_f;
    logic [7:0] off_f;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // well-formed flash sequence, mostly run to its end
      count_f = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 4));
      on_f  = pick_length();
      off_f = pick_length();
      if ($urandom_range(0, 3) == 0) begin
        send_simple(ACT_POLL);
      end
      send_item(ACT_FLASH, count_f, on_f, off_f, 1'($urandom_range(0, 1)));
      if (count_f == '0) begin
        n_ticks = $urandom_range(4, 40);
      end else begin
        n_ticks = int'(count_f) * (int'(on_f) + int'(off_f) + 2) + $urandom_range(1, 4);
      end
      if (n_ticks > 560) begin
        n_ticks = $urandom_range(40, 560);
      end
      // keep the total close to the item target
      if (n_ticks > ITEM_TARGET - items_sent + 20) begin
        n_ticks = ITEM_TARGET - items_sent + 20;
      end
      noisy = (n_ticks <= 100);
      for (int i = 0; i < n_ticks; i++) begin
        case ($urandom_range(0, 59))
          0, 1, 2: send_simple(ACT_POLL);
          3: begin
            if (noisy) send_simple(3'($urandom_range(0, 7)));
            else send_simple(ACT_TICK);
          end
          default: send_simple(ACT_TICK);
        endcase
      end
      send_simple(ACT_POLL);
    end else if (kind == 6) begin
      send_simple($urandom_range(0, 1) ? ACT_ON : ACT_OFF);
      repeat ($urandom_range(1, 6)) begin
        send_simple(($urandom_range(0, 4) == 0) ? ACT_POLL : ACT_TICK);
      end
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 8)) send_simple(3'($urandom_range(0, 7)));
    end else if (kind == 8) begin
      // several commands stack up; the last on, off or flash wins at the tick
      repeat ($urandom_range(2, 4)) begin
        case ($urandom_range(0, 3))
          0: send_simple(ACT_ON);
          1: send_simple(ACT_OFF);
          2: send_simple(ACT_FLASH);
          default: send_simple(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)));
        endcase
      end
      repeat ($urandom_range(1, 5)) send_simple(ACT_TICK);
    end else begin
      repeat ($urandom_range(1, 4)) send_simple(ACT_POLL);
    end
  endtask

  initial begin
    int   next_cfg_at;
    logic end_en;
    bit   hold_done;
    next_cfg_at = CFG_PHASE_ITEMS;
    end_en      = 1'b0;
    hold_done   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_end_enable(1'b1);
    send_simple(ACT_POLL);
    send_simple(ACT_TICK);
    send_simple(ACT_ON);
    send_simple(ACT_TICK);
    send_simple(ACT_OFF);
    send_simple(ACT_TICK);
    // single flash, zero-length phases
    send_item(ACT_FLASH, 8'd1, 8'd0, 8'd0, 1'b0);
    repeat (2) send_simple(ACT_TICK);
    send_simple(ACT_POLL);
    // two flashes, end right after the last on phase
    send_item(ACT_FLASH, 8'd2, 8'd0, 8'd0, 1'b1);
    repeat (3) send_simple(ACT_TICK);
    send_simple(ACT_POLL);
    // stacked commands: largest fields, then endless flash, then on wins
    send_item(ACT_FLASH, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(ACT_FLASH, 8'd0, 8'd1, 8'd1, 1'b0);
    send_simple(ACT_ON);
    send_simple(ACT_TICK);
    send_simple(ACT_SPARE_FIRST);
    send_simple(ACT_SPARE_LAST);
    send_simple(ACT_POLL);
    send_simple(ACT_OFF);
    send_simple(ACT_TICK);
    drain_reports();
    write_end_enable(end_en);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_cfg_at) begin
        drain_reports();
        end_en = ~end_en;
        write_end_enable(end_en);
        next_cfg_at += CFG_PHASE_ITEMS;
      end
      if (!hold_done && items_sent >= ITEM_TARGET / 2) begin
        // keep offering while the result side holds off, so the input backs up
        tx_gaps       = 1'b0;
        long_hold_req = 1'b1;
        repeat (24) send_simple(ACT_TICK);
        tx_gaps   = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent >= ITEM_TARGET - CALM_TAIL_ITEMS) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      run_scenario();
    end

    drain_reports();
    if (error_count == 0 && reports_owed == 0) begin
      $display("tb_led_flash_sequencer_top: clean");
    end else begin
      $display("tb_led_flash_sequencer_top: errors");
    end
    $finish;
  end

endmodule
